>>> rtl/mcd_pkg.sv
package mcd_pkg;

  // Input item kinds
  localparam logic KIND_TIME = 1'b0;
  localparam logic KIND_SCAN = 1'b1;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_MINUTE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_HOLD_TICKS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLINK_PERIOD     = 2'd2;
  localparam int unsigned CFG_DATA_W = 16;

  // Register reset values
  localparam logic [15:0] TICKS_PER_MINUTE_RST = 16'd4500;
  localparam logic [6:0]  LONG_HOLD_TICKS_RST  = 7'd75;
  localparam logic [7:0]  BLINK_PERIOD_RST     = 8'd75;

  // Display constants
  localparam int unsigned SCAN_POSITIONS = 5;
  localparam int unsigned SCAN_POS_W     = 3;
  localparam logic [7:0] SEG_COLON_ON    = 8'h3F;
  localparam logic [7:0] SEG_BLANK       = 8'hFF;
  localparam logic [7:0] BLINK_ON_BELOW  = 8'd38;
  localparam logic [7:0] BLINK_OFF_ABOVE = 8'd39;
  localparam logic [5:0] MINUTE_MAX      = 6'd59;
  localparam logic [4:0] HOUR_MAX        = 5'd23;
  localparam logic [6:0] SHORT_PRESS_MIN = 7'd3;
  localparam logic [6:0] PRESS_MAX       = 7'd127;

  // Active-low segment patterns, plain digits and blanked leading zero
  localparam logic [7:0] SEG_DIGIT [10] = '{
    8'h03, 8'h9F, 8'h25, 8'h0D, 8'h99, 8'h49, 8'h41, 8'h1B, 8'h01, 8'h09
  };
  localparam logic [7:0] SEG_LEAD [10] = '{
    8'hFF, 8'h9F, 8'h25, 8'h0D, 8'h99, 8'h49, 8'h41, 8'h1B, 8'h01, 8'h09
  };

  // Time state shown on the display
  typedef struct packed {
    logic [4:0] hours;
    logic [5:0] minutes;
    logic [7:0] colon;
  } mcd_disp_t;

  // Tens digit of a value below 64, by constant compares
  function automatic logic [2:0] tens_of(input logic [5:0] v);
    logic [2:0] t;
    if (v >= 6'd60)      t = 3'd6;
    else if (v >= 6'd50) t = 3'd5;
    else if (v >= 6'd40) t = 3'd4;
    else if (v >= 6'd30) t = 3'd3;
    else if (v >= 6'd20) t = 3'd2;
    else if (v >= 6'd10) t = 3'd1;
    else                 t = 3'd0;
    return t;
  endfunction

  // Ones digit of a value below 64
  function automatic logic [3:0] ones_of(input logic [5:0] v);
    logic [6:0] prod;
    logic [5:0] rem;
    prod = {4'd0, tens_of(v)} * 7'd10;
    rem  = v - prod[5:0];
    return rem[3:0];
  endfunction

endpackage

>>> rtl/multiplexed_clock_display.sv
// Channel | Dir | tdata (low bit up)                          | tuser
// in_     | in  | button_level, 7 zero bits                   | kind
// out_    | out | digit_select[4:0] segment_pattern[7:0]      | display_update
//         |     | hours_now[4:0] minutes_now[5:0]             |
// cfg_    | in  | cfg_index selects register, cfg_data value  | -
//
// One transaction per cycle while the output is not stalled: an item is held in the
// input register, then its result is registered on the output.
// Synchronous active-low reset clears control and time state; the colon is off.
// A stalled output holds its result and the input register; in_tready drops
// only while both are full.
module multiplexed_clock_display (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [7:0]                      in_tdata,   // [0] button_level
  input  logic                            in_tuser,   // [0] kind
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [23:0]                     out_tdata,  // [4:0] digit_select, [12:5] segment_pattern,
                                                      // [17:13] hours_now, [23:18] minutes_now
  output logic                            out_tuser,  // [0] display_update
  input  logic                            cfg_we,
  input  logic [mcd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mcd_pkg::CFG_DATA_W-1:0]  cfg_data
);

  logic       in_valid_r;
  logic       kind_r;
  logic       level_r;
  logic       advance;
  logic       tick_en;
  logic       scan_en;

  mcd_pkg::mcd_disp_t disp;
  logic [4:0] hours_nxt;
  logic [5:0] minutes_nxt;
  logic [4:0] sel;
  logic [7:0] seg;

  logic        out_valid_r;
  logic [23:0] out_data_r;
  logic        out_user_r;

  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;
  assign tick_en   = advance && (kind_r == mcd_pkg::KIND_TIME);
  assign scan_en   = advance && (kind_r == mcd_pkg::KIND_SCAN);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      kind_r  <= in_tuser;
      level_r <= in_tdata[0];
    end
  end

  mcd_time u_time (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .tick_en      (tick_en),
    .button_level (level_r),
    .disp         (disp),
    .hours_nxt    (hours_nxt),
    .minutes_nxt  (minutes_nxt)
  );

  mcd_scan u_scan (
    .clk             (clk),
    .rst_n           (rst_n),
    .scan_en         (scan_en),
    .disp            (disp),
    .digit_select    (sel),
    .segment_pattern (seg)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_user_r <= kind_r;
      if (kind_r == mcd_pkg::KIND_SCAN) begin
        out_data_r <= {minutes_nxt, hours_nxt, seg, sel};
      end else begin
        out_data_r <= {minutes_nxt, hours_nxt, mcd_pkg::SEG_BLANK, 5'b00000};
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

>>> rtl/mcd_time.sv
module mcd_time (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [mcd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mcd_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                               tick_en,
  input  logic                               button_level,
  output mcd_pkg::mcd_disp_t                 disp,
  output logic [4:0]                         hours_nxt,
  output logic [5:0]                         minutes_nxt
);

  logic [15:0] tpm_r;
  logic [6:0]  lht_r;
  logic [7:0]  bp_r;

  logic [15:0] cnt_r, cnt_nxt;
  logic [7:0]  phase_r, phase_nxt;
  logic [7:0]  colon_r, colon_nxt;
  logic [5:0]  min_r;
  logic [4:0]  hour_r;
  logic [6:0]  press_r, press_nxt;

  logic [16:0] cnt_inc;
  logic [8:0]  phase_inc;
  logic        min_wrap;
  logic [5:0]  min_a;
  logic [4:0]  hour_a;
  logic [6:0]  press_inc;
  logic        press_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tpm_r <= mcd_pkg::TICKS_PER_MINUTE_RST;
      lht_r <= mcd_pkg::LONG_HOLD_TICKS_RST;
      bp_r  <= mcd_pkg::BLINK_PERIOD_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mcd_pkg::CFG_TICKS_PER_MINUTE: tpm_r <= cfg_data;
        mcd_pkg::CFG_LONG_HOLD_TICKS:  lht_r <= cfg_data[6:0];
        mcd_pkg::CFG_BLINK_PERIOD:     bp_r  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    colon_nxt = colon_r;
    if (phase_r < mcd_pkg::BLINK_ON_BELOW)  colon_nxt = mcd_pkg::SEG_COLON_ON;
    if (phase_r > mcd_pkg::BLINK_OFF_ABOVE) colon_nxt = mcd_pkg::SEG_BLANK;

    phase_inc = {1'b0, phase_r} + 9'd1;
    phase_nxt = (phase_inc >= {1'b0, bp_r}) ? 8'd0 : phase_inc[7:0];

    // Minute rollover also resets the blink phase
    cnt_inc  = {1'b0, cnt_r} + 17'd1;
    min_wrap = (cnt_inc >= {1'b0, tpm_r});
    min_a    = min_r;
    hour_a   = hour_r;
    if (min_wrap) begin
      cnt_nxt   = 16'd0;
      phase_nxt = 8'd0;
      if (min_r >= mcd_pkg::MINUTE_MAX) begin
        min_a  = 6'd0;
        hour_a = (hour_r >= mcd_pkg::HOUR_MAX) ? 5'd0 : hour_r + 5'd1;
      end else begin
        min_a = min_r + 6'd1;
      end
    end else begin
      cnt_nxt = cnt_inc[15:0];
    end

    hours_nxt   = hour_a;
    minutes_nxt = min_a;
    press_ok    = ({1'b0, press_r} < ({1'b0, lht_r} + 8'd1)) && (press_r < mcd_pkg::PRESS_MAX);
    press_inc   = press_ok ? press_r + 7'd1 : press_r;
    if (!button_level) begin
      press_nxt = press_inc;
      // Long hold: advance the hour when the count reaches the threshold; once, unless the threshold is 127
      if (press_inc == lht_r) begin
        hours_nxt = (hour_a >= mcd_pkg::HOUR_MAX) ? 5'd0 : hour_a + 5'd1;
      end
    end else begin
      press_nxt = 7'd0;
      // Short press on release: advance the minute without carry
      if (press_r > mcd_pkg::SHORT_PRESS_MIN && press_r < lht_r) begin
        minutes_nxt = (min_a >= mcd_pkg::MINUTE_MAX) ? 6'd0 : min_a + 6'd1;
      end
    end

    if (!tick_en) begin
      hours_nxt   = hour_r;
      minutes_nxt = min_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= 16'd0;
      phase_r <= 8'd0;
      colon_r <= mcd_pkg::SEG_BLANK;
      min_r   <= 6'd0;
      hour_r  <= 5'd0;
      press_r <= 7'd0;
    end else if (tick_en) begin
      cnt_r   <= cnt_nxt;
      phase_r <= phase_nxt;
      colon_r <= colon_nxt;
      min_r   <= minutes_nxt;
      hour_r  <= hours_nxt;
      press_r <= press_nxt;
    end
  end

  assign disp.hours   = hour_r;
  assign disp.minutes = min_r;
  assign disp.colon   = colon_r;

endmodule

>>> rtl/mcd_scan.sv
module mcd_scan (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                scan_en,
  input  mcd_pkg::mcd_disp_t  disp,
  output logic [4:0]          digit_select,
  output logic [7:0]          segment_pattern
);

  logic [mcd_pkg::SCAN_POS_W-1:0] pos_r, pos_nxt;
  logic [3:0]                     digit;

  always_comb begin
    digit_select    = 5'b00000;
    segment_pattern = mcd_pkg::SEG_BLANK;
    digit           = 4'd0;
    unique case (pos_r)
      3'd0: begin
        digit_select    = 5'b00001;
        digit           = mcd_pkg::ones_of(disp.minutes);
        segment_pattern = mcd_pkg::SEG_DIGIT[digit];
      end
      3'd1: begin
        digit_select    = 5'b00010;
        digit           = {1'b0, mcd_pkg::tens_of(disp.minutes)};
        segment_pattern = mcd_pkg::SEG_DIGIT[digit];
      end
      3'd2: begin
        digit_select    = 5'b00100;
        digit           = mcd_pkg::ones_of({1'b0, disp.hours});
        segment_pattern = mcd_pkg::SEG_DIGIT[digit];
      end
      3'd3: begin
        digit_select    = 5'b01000;
        digit           = {1'b0, mcd_pkg::tens_of({1'b0, disp.hours})};
        segment_pattern = mcd_pkg::SEG_LEAD[digit];
      end
      default: begin
        digit_select    = 5'b10000;
        segment_pattern = disp.colon;
      end
    endcase

    pos_nxt = (pos_r >= mcd_pkg::SCAN_POS_W'(mcd_pkg::SCAN_POSITIONS - 1))
              ? '0 : pos_r + mcd_pkg::SCAN_POS_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else if (scan_en) begin
      pos_r <= pos_nxt;
    end
  end

endmodule
